// ===== hdl/tep_pkg.sv =====
// Shared types, constants and decode functions for the terminal escape and UTF-8 parser.
// No dependencies; every other file of the block refers to this package by scoped names.
package tep_pkg;

  // Numeric parameters of escape sequences saturate at 2^PW - 1.
  localparam int PW = 16;
  localparam logic [PW-1:0] PMAX = '1;

  // Depth of the job queue between the parser and the result stage.
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // Screen command codes.
  localparam logic [5:0] OP_PUT_CHAR        = 6'd0;
  localparam logic [5:0] OP_TAB             = 6'd1;
  localparam logic [5:0] OP_CURSOR_DOWN     = 6'd2;
  localparam logic [5:0] OP_CURSOR_LEFT     = 6'd3;
  localparam logic [5:0] OP_CARRIAGE_RETURN = 6'd4;
  localparam logic [5:0] OP_CLR_BOL         = 6'd5;
  localparam logic [5:0] OP_EXIT_ATTR       = 6'd6;
  localparam logic [5:0] OP_ENTER_BOLD      = 6'd7;
  localparam logic [5:0] OP_ENTER_REVERSE   = 6'd8;
  localparam logic [5:0] OP_EXIT_BOLD       = 6'd9;
  localparam logic [5:0] OP_SET_FG          = 6'd10;
  localparam logic [5:0] OP_SET_BG          = 6'd11;
  localparam logic [5:0] OP_PARM_UP         = 6'd12;
  localparam logic [5:0] OP_PARM_DOWN       = 6'd13;
  localparam logic [5:0] OP_PARM_RIGHT      = 6'd14;
  localparam logic [5:0] OP_PARM_LEFT       = 6'd15;
  localparam logic [5:0] OP_COLUMN_ADDR     = 6'd16;
  localparam logic [5:0] OP_PARM_INS_LINE   = 6'd17;
  localparam logic [5:0] OP_PARM_DEL_LINE   = 6'd18;
  localparam logic [5:0] OP_PARM_DCH        = 6'd19;
  localparam logic [5:0] OP_PARM_INDEX      = 6'd20;
  localparam logic [5:0] OP_PARM_RINDEX     = 6'd21;
  localparam logic [5:0] OP_ERASE_CHARS     = 6'd22;
  localparam logic [5:0] OP_PARM_ICH        = 6'd23;
  localparam logic [5:0] OP_ROW_ADDR        = 6'd24;
  localparam logic [5:0] OP_CURSOR_ADDR     = 6'd25;
  localparam logic [5:0] OP_INSERT_CHAR     = 6'd26;
  localparam logic [5:0] OP_CURSOR_UP       = 6'd27;
  localparam logic [5:0] OP_CURSOR_RIGHT    = 6'd28;
  localparam logic [5:0] OP_CURSOR_HOME     = 6'd29;
  localparam logic [5:0] OP_CLR_EOS         = 6'd30;
  localparam logic [5:0] OP_CLR_EOL         = 6'd31;
  localparam logic [5:0] OP_INSERT_LINE     = 6'd32;
  localparam logic [5:0] OP_DELETE_LINE     = 6'd33;
  localparam logic [5:0] OP_DELETE_CHAR     = 6'd34;
  localparam logic [5:0] OP_SCROLL_REVERSE  = 6'd35;
  localparam logic [5:0] OP_END_OF_STREAM   = 6'd36;

  // Byte values with a meaning to the parser.
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_M = 8'h6D;

  // One screen command.
  typedef struct packed {
    logic        vld;
    logic [5:0]  op;
    logic [31:0] a;
    logic [16:0] b;
  } res_t;

  // Work for the result stage: one command, optionally followed by a second SGR command.
  typedef struct packed {
    logic        two;
    logic [5:0]  op0;
    logic [31:0] a0;
    logic [16:0] b0;
    logic [5:0]  op1;
    logic [2:0]  a1;
  } job_t;

  function automatic res_t mk(input logic [5:0] op, input logic [31:0] a,
                              input logic [16:0] b);
    res_t r;
    r.vld = 1'b1;
    r.op  = op;
    r.a   = a;
    r.b   = b;
    return r;
  endfunction

  // Decimal accumulate with saturation: v * 10 + d.
  function automatic logic [PW-1:0] acc(input logic [PW-1:0] v, input logic [3:0] d);
    logic [PW+3:0] r;
    r = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (PW+4)'(d);
    return (r[PW+3:PW] != 4'b0) ? PMAX : r[PW-1:0];
  endfunction

  // Select Graphic Rendition code to attribute or colour command.
  function automatic res_t sgr(input logic [PW-1:0] x);
    res_t r;
    r = '0;
    r.vld = 1'b1;
    if (x == PW'(0)) r.op = OP_EXIT_ATTR;
    else if (x == PW'(1)) r.op = OP_ENTER_BOLD;
    else if (x == PW'(7)) r.op = OP_ENTER_REVERSE;
    else if (x == PW'(22)) r.op = OP_EXIT_BOLD;
    else if (x >= PW'(30) && x <= PW'(37)) begin
      r.op = OP_SET_FG;
      r.a  = 32'(x) - 32'd30;
    end else if (x == PW'(39)) begin
      r.op = OP_SET_FG;
      r.a  = 32'd7;
    end else if (x >= PW'(40) && x <= PW'(47)) begin
      r.op = OP_SET_BG;
      r.a  = 32'(x) - 32'd40;
    end else if (x == PW'(49)) r.op = OP_SET_BG;
    else r.vld = 1'b0;
    return r;
  endfunction

  // CSI final byte without parameters.
  function automatic res_t csi_none(input logic [7:0] c);
    res_t r;
    r = '0;
    r.vld = 1'b1;
    case (c)
      CH_AT:      r.op = OP_INSERT_CHAR;
      CH_A:       r.op = OP_CURSOR_UP;
      CH_B:       r.op = OP_CURSOR_DOWN;
      CH_C:       r.op = OP_CURSOR_RIGHT;
      CH_D:       r.op = OP_CURSOR_LEFT;
      CH_H:       r.op = OP_CURSOR_HOME;
      CH_I:       r.op = OP_TAB;
      CH_J:       r.op = OP_CLR_EOS;
      CH_K:       r.op = OP_CLR_EOL;
      CH_L:       r.op = OP_INSERT_LINE;
      CH_M:       r.op = OP_DELETE_LINE;
      CH_P:       r.op = OP_DELETE_CHAR;
      CH_LOWER_M: r.op = OP_EXIT_ATTR;
      default:    r.vld = 1'b0;
    endcase
    return r;
  endfunction

  // CSI final byte with one parameter.
  function automatic res_t csi_one(input logic [7:0] c, input logic [PW-1:0] x);
    res_t r;
    logic [31:0] xa;
    r  = '0;
    xa = 32'(x);
    r.vld = 1'b1;
    r.a   = xa;
    case (c)
      CH_LOWER_M: r = sgr(x);
      CH_K: begin
        r.a = '0;
        r.op = OP_CLR_BOL;
        r.vld = (x == PW'(1));
      end
      CH_A:       r.op = OP_PARM_UP;
      CH_B:       r.op = OP_PARM_DOWN;
      CH_C:       r.op = OP_PARM_RIGHT;
      CH_D:       r.op = OP_PARM_LEFT;
      CH_G: begin
        r.op = OP_COLUMN_ADDR;
        r.a  = xa - 32'd1;
      end
      CH_L:       r.op = OP_PARM_INS_LINE;
      CH_M:       r.op = OP_PARM_DEL_LINE;
      CH_P:       r.op = OP_PARM_DCH;
      CH_S:       r.op = OP_PARM_INDEX;
      CH_T:       r.op = OP_PARM_RINDEX;
      CH_X:       r.op = OP_ERASE_CHARS;
      CH_AT:      r.op = OP_PARM_ICH;
      CH_LOWER_D: begin
        r.op = OP_ROW_ADDR;
        r.a  = xa - 32'd1;
      end
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/tep_front.sv =====
// Byte parser of the terminal escape and UTF-8 parser: sequence state and job building.
// Depends on tep_pkg.
module tep_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata,
  output logic            job_push,
  output tep_pkg::job_t   job
);

  typedef enum logic [6:0] {
    PH_GROUND = 7'b0000001,
    PH_ESC    = 7'b0000010,
    PH_CSI    = 7'b0000100,
    PH_FIRST  = 7'b0001000,
    PH_SEMI   = 7'b0010000,
    PH_SECOND = 7'b0100000,
    PH_UTF8   = 7'b1000000
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              term_r;
  logic [tep_pkg::PW-1:0]  first_r, first_nxt;
  logic [tep_pkg::PW-1:0]  second_r, second_nxt;
  logic [30:0]             cp_r, cp_nxt;
  logic [2:0]              rem_r, rem_nxt;
  logic [30:0]             cp_shift;
  logic                    accept;
  logic                    dig;
  logic [3:0]              d;
  tep_pkg::res_t           r0, r1;

  assign accept   = push & ~q_full;
  assign dig      = (in_byte >= tep_pkg::CH_ZERO) && (in_byte <= tep_pkg::CH_NINE);
  assign d        = in_byte[3:0];
  assign cp_shift = {cp_r[24:0], in_byte[5:0]};

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    cp_nxt     = cp_r;
    rem_nxt    = rem_r;
    r0         = '0;
    r1         = '0;
    if (accept) begin
      phase_nxt = PH_GROUND;
      case (phase_r)
        PH_ESC: begin
          if (in_byte == tep_pkg::CH_LBRACK) phase_nxt = PH_CSI;
          else if (in_byte == tep_pkg::CH_M)
            r0 = tep_pkg::mk(tep_pkg::OP_SCROLL_REVERSE, '0, '0);
        end
        PH_CSI: begin
          if (dig) begin
            first_nxt = tep_pkg::PW'(d);
            phase_nxt = PH_FIRST;
          end else r0 = tep_pkg::csi_none(in_byte);
        end
        PH_FIRST: begin
          if (dig) begin
            first_nxt = tep_pkg::acc(first_r, d);
            phase_nxt = PH_FIRST;
          end else if (in_byte == tep_pkg::CH_SEMI) begin
            second_nxt = '0;
            phase_nxt  = PH_SEMI;
          end else r0 = tep_pkg::csi_one(in_byte, first_r);
        end
        PH_SEMI: begin
          if (dig) begin
            second_nxt = tep_pkg::PW'(d);
            phase_nxt  = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (dig) begin
            second_nxt = tep_pkg::acc(second_r, d);
            phase_nxt  = PH_SECOND;
          end else if (in_byte == tep_pkg::CH_LOWER_M) begin
            r0 = tep_pkg::sgr(first_r);
            r1 = tep_pkg::sgr(second_r);
          end else if (in_byte == tep_pkg::CH_H) begin
            r0 = tep_pkg::mk(tep_pkg::OP_CURSOR_ADDR, 32'(first_r) - 32'd1,
                             17'(second_r) - 17'd1);
          end
        end
        PH_UTF8: begin
          if (rem_r > 3'd1) begin
            cp_nxt    = cp_shift;
            rem_nxt   = rem_r - 3'd1;
            phase_nxt = PH_UTF8;
          end else begin
            rem_nxt = '0;
            cp_nxt  = '0;
            r0      = tep_pkg::mk(tep_pkg::OP_PUT_CHAR, 32'(cp_shift), '0);
          end
        end
        default: begin
          if (in_byte == term_r) begin
            r0 = tep_pkg::mk(tep_pkg::OP_END_OF_STREAM, '0, '0);
          end else begin
            case (in_byte)
              tep_pkg::CH_BEL: r0 = '0;
              tep_pkg::CH_TAB: r0 = tep_pkg::mk(tep_pkg::OP_TAB, '0, '0);
              tep_pkg::CH_LF:  r0 = tep_pkg::mk(tep_pkg::OP_CURSOR_DOWN, '0, '0);
              tep_pkg::CH_BS:  r0 = tep_pkg::mk(tep_pkg::OP_CURSOR_LEFT, '0, '0);
              tep_pkg::CH_CR:  r0 = tep_pkg::mk(tep_pkg::OP_CARRIAGE_RETURN, '0, '0);
              tep_pkg::CH_ESC: phase_nxt = PH_ESC;
              default: begin
                if (!in_byte[7]) begin
                  r0 = tep_pkg::mk(tep_pkg::OP_PUT_CHAR, 32'(in_byte), '0);
                end else if (in_byte[7:5] == 3'b110) begin
                  cp_nxt = 31'(in_byte[4:0]);
                  rem_nxt = 3'd1;
                  phase_nxt = PH_UTF8;
                end else if (in_byte[7:4] == 4'b1110) begin
                  cp_nxt = 31'(in_byte[3:0]);
                  rem_nxt = 3'd2;
                  phase_nxt = PH_UTF8;
                end else if (in_byte[7:3] == 5'b11110) begin
                  cp_nxt = 31'(in_byte[2:0]);
                  rem_nxt = 3'd3;
                  phase_nxt = PH_UTF8;
                end else if (in_byte[7:2] == 6'b111110) begin
                  cp_nxt = 31'(in_byte[1:0]);
                  rem_nxt = 3'd4;
                  phase_nxt = PH_UTF8;
                end else if (in_byte[7:1] == 7'b1111110) begin
                  cp_nxt = 31'(in_byte[0]);
                  rem_nxt = 3'd5;
                  phase_nxt = PH_UTF8;
                end else begin
                  // Bad lead byte decodes to character zero.
                  r0 = tep_pkg::mk(tep_pkg::OP_PUT_CHAR, '0, '0);
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // Pack up to two commands; a missing first SGR result lets the second move up.
  always_comb begin
    job      = '0;
    job_push = 1'b0;
    if (r0.vld) begin
      job_push = 1'b1;
      job.op0  = r0.op;
      job.a0   = r0.a;
      job.b0   = r0.b;
      job.two  = r1.vld;
      job.op1  = r1.op;
      job.a1   = r1.a[2:0];
    end else if (r1.vld) begin
      job_push = 1'b1;
      job.op0  = r1.op;
      job.a0   = r1.a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GROUND;
      term_r  <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      if (cfg_we) term_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    cp_r     <= cp_nxt;
  end

endmodule

// ===== hdl/tep_queue.sv =====
// Short job queue between the parser and the result stage of the escape/UTF-8 parser.
// Depends on tep_pkg for the job type and depth.
module tep_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  tep_pkg::job_t   wr_data,
  output logic            full,
  input  logic            rd_en,
  output tep_pkg::job_t   rd_data,
  output logic            nempty
);

  tep_pkg::job_t          slot_r [tep_pkg::QDEPTH];
  logic [tep_pkg::QAW-1:0] wp_r, rp_r;
  logic [tep_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic                    do_wr, do_rd;

  assign full    = (cnt_r == (tep_pkg::QAW+1)'(tep_pkg::QDEPTH));
  assign nempty  = (cnt_r != '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & nempty;
  assign rd_data = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wp_r] <= wr_data;
  end

endmodule

// ===== hdl/tep_back.sv =====
// Result stage of the escape/UTF-8 parser: splits each job into one or two commands.
// Depends on tep_pkg for the job type.
module tep_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_nempty,
  input  tep_pkg::job_t       q_data,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output logic [5:0]          out_op,
  output logic signed [31:0]  out_value_a,
  output logic signed [16:0]  out_value_b,
  output logic                out_last
);

  logic sel_r, sel_nxt;
  logic taken;

  assign empty       = ~q_nempty;
  assign out_op      = sel_r ? q_data.op1 : q_data.op0;
  assign out_value_a = sel_r ? 32'(q_data.a1) : q_data.a0;
  assign out_value_b = sel_r ? '0 : q_data.b0;
  assign out_last    = sel_r | ~q_data.two;
  assign taken       = pop & q_nempty;
  assign q_rd        = taken & out_last;

  always_comb begin
    sel_nxt = sel_r;
    if (taken) sel_nxt = ~out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else sel_r <= sel_nxt;
  end

endmodule

// ===== hdl/terminal_escape_and_utf8_parser.sv =====
// Top level of the terminal escape and UTF-8 parser: parser, job queue and result stage.
// Depends on tep_pkg, tep_front, tep_queue and tep_back.
//
//   Channel   Handshake            Payload
//   input     push / full          in_byte
//   result    empty / pop          out_op, out_value_a, out_value_b, out_last
//   config    cfg_we (no wait)     cfg_wdata (terminator byte)
//
// The parser takes one byte in every cycle in which full is low; its sequence state
// updates in that same cycle, so the loop through the phase register sets the rate.
// A byte that yields commands puts one job into a four-entry queue; the result stage
// shows a job from the queue head for one pop (one command) or two pops (SGR pair).
// Reset is synchronous and active low and empties the queue and returns to ground state.
// A stalled result side fills the queue and then raises full; nothing is dropped.
module terminal_escape_and_utf8_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          in_byte,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output logic [5:0]          out_op,
  output logic signed [31:0]  out_value_a,
  output logic signed [16:0]  out_value_b,
  output logic                out_last,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  // Jobs flow from the parser into the queue and out to the result stage.
  tep_pkg::job_t job_in, job_out;
  logic          job_push;
  logic          q_full, q_nempty, q_rd;

  // The parser sees the queue's full flag, which is also the input channel's back-pressure.
  assign full = q_full;

  tep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  tep_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (job_out),
    .nempty  (q_nempty)
  );

  // The result stage retires a queue entry only after its final command is popped.
  tep_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_nempty    (q_nempty),
    .q_data      (job_out),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .out_op      (out_op),
    .out_value_a (out_value_a),
    .out_value_b (out_value_b),
    .out_last    (out_last)
  );

endmodule
